// File: hw/rtl/salru_pkg.sv
`timescale 1ns / 1ps
// Shared constants and payload types for the size-aware LRU replacement block.
package salru_pkg;

	localparam int ENTRIES = 32;
	localparam int IW      = $clog2(ENTRIES);

	localparam logic [31:0] CAP_RESET = 32'd1048576;
	localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_SET = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_REJECTED = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [63:0] key;
		logic [31:0] req_size;
	} in_word_t;

	typedef struct packed {
		logic        is_eviction;
		logic [63:0] evicted_key;
		logic [31:0] evicted_size;
		logic        hit;
		logic        status;
		logic [31:0] found_size;
		logic [31:0] mem_used;
		logic        last;
	} out_word_t;

endpackage

// File: hw/rtl/size_aware_lru_cache_policy_top.sv
`timescale 1ns / 1ps
// Size-aware LRU replacement policy: slot table, scan sequencer and result register.
//
// Usage
//   Input channel (in_valid / in_stall / in_data) carries one get or set word.
//   Output channel (out_valid / out_stall / out_data) carries result words: one per
//   eviction, then one final word with last set. cfg_we / cfg_wdata write the byte
//   budget.
// Scanning
//   Every key lookup and every oldest-entry search is a scan of one slot per cycle
//   through a single shared compare unit; a key hit ends the scan early. A set
//   larger than the budget is rejected without a scan. When the recency counter
//   saturates, the stamps are renumbered by successive oldest searches, one per
//   stored entry and a last one that finds none.
//   One word is in work at a time; in_stall is high from acceptance until the final
//   result has been loaded into the output register.
// Reset
//   All slots empty, nothing in use, budget 1048576; no clearing pass is needed.
// Back-pressure
//   A result waits in the output register while out_stall is high; the sequencer
//   holds until the register is free, and the next word may be accepted while the
//   final result of the previous one still waits there.
module size_aware_lru_cache_policy_top
	import salru_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data,
	input  logic      cfg_we,
	input  logic [31:0] cfg_wdata
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_SCAN,
		S_DISP,
		S_EVICT,
		S_UPD,
		S_INS,
		S_TOUCH,
		S_FINAL
	} state_t;

	typedef enum logic [2:0] {
		P_GET,
		P_SPACE,
		P_SETKEY,
		P_FULL,
		P_RENUM
	} purpose_t;

	state_t   state_q;
	purpose_t purp_q;

	// slot table
	logic [ENTRIES-1:0] slot_valid_q;
	logic [ENTRIES-1:0] done_q;
	logic [63:0]        slot_key_q   [ENTRIES];
	logic [31:0]        slot_size_q  [ENTRIES];
	logic [31:0]        slot_stamp_q [ENTRIES];

	logic [31:0] cap_q;
	logic [31:0] used_q;
	logic [31:0] clock_q;

	// captured word and working registers
	logic        cmd_q;
	logic [63:0] key_q;
	logic [31:0] size_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] slot_q;
	logic [IW-1:0] best_q;
	logic [31:0] best_stamp_q;
	logic        best_ok_q;
	logic        hit_q;
	logic        status_q;
	logic [31:0] found_q;

	logic      out_valid_q;
	out_word_t out_q;

	logic [IW-1:0] rd_idx;
	logic [63:0]   rd_key;
	logic [31:0]   rd_size;
	logic [31:0]   rd_stamp;
	logic          rd_valid;
	logic          key_match;
	logic          cand;
	logic          cand_older;
	logic          out_free;
	logic          out_load;
	logic          over_budget;
	logic          free_ok;
	logic [IW-1:0] free_idx;

	// single read port: scan index while scanning, else the chosen slot
	always_comb begin
		rd_idx     = (state_q == S_SCAN) ? idx_q : slot_q;
		rd_key     = slot_key_q[rd_idx];
		rd_size    = slot_size_q[rd_idx];
		rd_stamp   = slot_stamp_q[rd_idx];
		rd_valid   = slot_valid_q[rd_idx];
		key_match  = rd_valid && (rd_key == key_q);
		cand       = rd_valid && !done_q[rd_idx];
		cand_older = cand && (!best_ok_q || (rd_stamp < best_stamp_q));
	end

	// budget check on a widened sum
	assign over_budget = ({1'b0, used_q} + {1'b0, size_q}) > {1'b0, cap_q};

	// lowest empty slot
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!slot_valid_q[i]) begin
				free_ok  = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = out_free && (state_q == S_EVICT || state_q == S_FINAL);
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// sequencer, slot table and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			purp_q       <= P_GET;
			slot_valid_q <= '0;
			done_q       <= '0;
			cap_q        <= CAP_RESET;
			used_q       <= '0;
			clock_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one loads now
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q    <= in_data.cmd;
						key_q    <= in_data.key;
						size_q   <= in_data.req_size;
						hit_q    <= 1'b0;
						found_q  <= '0;
						if (in_data.cmd == CMD_GET) begin
							status_q <= STATUS_OK;
							purp_q   <= P_GET;
							idx_q    <= '0;
							state_q  <= S_SCAN;
						end else if (in_data.req_size > cap_q) begin
							status_q <= STATUS_REJECTED;
							state_q  <= S_FINAL;
						end else begin
							status_q <= STATUS_OK;
							state_q  <= S_CHK;
						end
					end
				end

				// evict for space, or go look the key up
				S_CHK: begin
					idx_q     <= '0;
					best_ok_q <= 1'b0;
					hit_q     <= 1'b0;
					purp_q    <= over_budget ? P_SPACE : P_SETKEY;
					state_q   <= S_SCAN;
				end

				// one slot per cycle through the compare unit
				S_SCAN: begin
					if (purp_q == P_GET || purp_q == P_SETKEY) begin
						if (key_match) begin
							hit_q   <= 1'b1;
							slot_q  <= idx_q;
							state_q <= S_DISP;
						end else if (idx_q == IW'(ENTRIES - 1)) begin
							state_q <= S_DISP;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						if (cand_older) begin
							best_ok_q    <= 1'b1;
							best_q       <= idx_q;
							best_stamp_q <= rd_stamp;
						end
						if (idx_q == IW'(ENTRIES - 1)) begin
							state_q <= S_DISP;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end

				// act on the scan outcome
				S_DISP: begin
					idx_q     <= '0;
					best_ok_q <= 1'b0;
					case (purp_q)
						P_GET: begin
							if (hit_q) begin
								found_q <= rd_size;
								state_q <= S_TOUCH;
							end else begin
								state_q <= S_FINAL;
							end
						end
						P_SPACE: begin
							if (best_ok_q) begin
								slot_q  <= best_q;
								state_q <= S_EVICT;
							end else begin
								hit_q   <= 1'b0;
								purp_q  <= P_SETKEY;
								state_q <= S_SCAN;
							end
						end
						P_SETKEY: begin
							if (hit_q) begin
								state_q <= S_UPD;
							end else if (free_ok) begin
								slot_q  <= free_idx;
								state_q <= S_INS;
							end else begin
								purp_q  <= P_FULL;
								state_q <= S_SCAN;
							end
						end
						P_FULL: begin
							if (best_ok_q) begin
								slot_q  <= best_q;
								state_q <= S_EVICT;
							end else begin
								slot_q  <= '0;
								state_q <= S_INS;
							end
						end
						P_RENUM: begin
							if (best_ok_q) begin
								slot_stamp_q[best_q] <= clock_q;
								done_q[best_q]       <= 1'b1;
								clock_q              <= clock_q + 1'b1;
								state_q              <= S_SCAN;
							end else begin
								done_q  <= '0;
								state_q <= S_TOUCH;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end

				// report the victim and free its slot
				S_EVICT: begin
					if (out_free) begin
						out_valid_q        <= 1'b1;
						out_q.is_eviction  <= 1'b1;
						out_q.evicted_key  <= rd_key;
						out_q.evicted_size <= rd_size;
						out_q.hit          <= 1'b0;
						out_q.status       <= STATUS_OK;
						out_q.found_size   <= '0;
						out_q.mem_used     <= used_q - rd_size;
						out_q.last         <= 1'b0;
						slot_valid_q[slot_q] <= 1'b0;
						used_q             <= used_q - rd_size;
						state_q            <= (purp_q == P_SPACE) ? S_CHK : S_INS;
					end
				end

				// replace the stored size of a present key
				S_UPD: begin
					used_q              <= used_q - rd_size + size_q;
					slot_size_q[slot_q] <= size_q;
					state_q             <= S_TOUCH;
				end

				// fill a slot with the new key
				S_INS: begin
					slot_valid_q[slot_q] <= 1'b1;
					slot_key_q[slot_q]   <= key_q;
					slot_size_q[slot_q]  <= size_q;
					used_q               <= used_q + size_q;
					hit_q                <= 1'b0;
					state_q              <= S_TOUCH;
				end

				// stamp as most recent, renumbering first if the counter is spent
				S_TOUCH: begin
					if (clock_q == STAMP_MAX) begin
						clock_q   <= '0;
						done_q    <= '0;
						idx_q     <= '0;
						best_ok_q <= 1'b0;
						purp_q    <= P_RENUM;
						state_q   <= S_SCAN;
					end else begin
						slot_stamp_q[slot_q] <= clock_q;
						clock_q              <= clock_q + 1'b1;
						state_q              <= S_FINAL;
					end
				end

				S_FINAL: begin
					if (out_free) begin
						out_valid_q        <= 1'b1;
						out_q.is_eviction  <= 1'b0;
						out_q.evicted_key  <= '0;
						out_q.evicted_size <= '0;
						out_q.hit          <= hit_q;
						out_q.status       <= status_q;
						out_q.found_size   <= found_q;
						out_q.mem_used     <= used_q;
						out_q.last         <= 1'b1;
						state_q            <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// evictions belong to set words only
	a_evict_on_set: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_eviction) |-> (cmd_q == CMD_SET))
		else $error("eviction word issued for a get");

	// a word is either an eviction or the final one, never both
	a_evict_xor_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.is_eviction != out_q.last))
		else $error("eviction and last flags disagree");

	// only a stored entry may be evicted
	a_victim_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVICT) |-> slot_valid_q[slot_q])
		else $error("eviction of an empty slot");

	// the touched slot holds an entry
	a_touch_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TOUCH) |-> slot_valid_q[slot_q])
		else $error("recency update on an empty slot");

	// an eviction is followed by a fresh space check or the insert
	a_evict_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVICT && out_free) |=> (state_q == S_CHK || state_q == S_INS))
		else $error("unexpected step after eviction");

endmodule
